>>> rtl/core/sorted_record_table_unit_assert.svh
// Assertion macros shared by the record table RTL.
`ifndef SORTED_RECORD_TABLE_UNIT_ASSERT_SVH
`define SORTED_RECORD_TABLE_UNIT_ASSERT_SVH

`define SRT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define SRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/srt_pkg.sv
`default_nettype none
package srt_pkg;
   localparam int TableDepth = 64;
   localparam int KeyWidth = 16;
   localparam int StopsWidth = 10;
   localparam int DurWidth = 16;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_STATS  = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [KeyWidth-1:0]   key;
      logic [StopsWidth-1:0] stops;
      logic [DurWidth-1:0]   dur;
   } record_type;

   // Per-cycle control broadcast to every cell.
   typedef struct packed {
      logic insert_shift;
      logic delete_shift;
      logic rotate;
   } cell_ctrl_type;
endpackage
`default_nettype wire

>>> rtl/core/srt_cell.sv
`default_nettype none
module srt_cell (
   input  wire                   clock,
   input  srt_pkg::cell_ctrl_type ctrl,
   input  wire                   take_new,
   input  wire                   take_right,
   input  srt_pkg::record_type   new_rec,
   input  srt_pkg::record_type   left_rec,
   input  srt_pkg::record_type   right_rec,
   output srt_pkg::record_type   rec
);
   srt_pkg::record_type rec_ff, rec_in;

   always_comb begin
      rec_in = rec_ff;
      if (ctrl.rotate) begin
         rec_in = right_rec;
      end else if (ctrl.insert_shift) begin
         if (take_new) begin
            rec_in = new_rec;
         end else if (take_right) begin
            rec_in = left_rec;
         end
      end else if (ctrl.delete_shift && take_right) begin
         rec_in = right_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;
endmodule
`default_nettype wire

>>> rtl/core/srt_divider.sv
`default_nettype none
module srt_divider #(
   parameter int NumWidth = 32,
   parameter int DenWidth = 11
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire [NumWidth-1:0]  numer,
   input  wire [DenWidth-1:0]  denom,
   output logic                done,
   output logic [NumWidth-1:0] quot
);
   localparam int CntWidth = $clog2(NumWidth + 1);
   logic [NumWidth-1:0] q_ff, q_in;
   logic [DenWidth:0]   r_ff, r_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [DenWidth:0]   trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[DenWidth-1:0], q_ff[NumWidth-1]};
      if (start) begin
         q_in = numer;
         r_in = '0;
         cnt_in = CntWidth'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, denom}) begin
            r_in = trial - {1'b0, denom};
            q_in = {q_ff[NumWidth-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

>>> rtl/core/sorted_record_table_unit.sv
`default_nettype none
// Sorted record table: a row of TABLE_DEPTH cells holds records in ascending key
// order. Each request word takes one operation and yields one response word, and a
// new request word is taken only after the previous response word has been taken.
// An insert or delete passes through the scan state and then compares and shifts
// every cell in parallel in the shift state; the result state then registers its
// response word. A search and a statistics query rotate the row once through the
// cell at position zero, one record per cycle, so a search, or a query on an empty
// table, moves from the scan state straight to the result state. A query on a
// non-empty table then runs two bit-serial divisions side by side and moves to the
// result state when the longer one, the duration division, is done. A full table
// does the same work. Records are not cleared at reset.
`include "sorted_record_table_unit_assert.svh"
module sorted_record_table_unit #(
   parameter int TABLE_DEPTH = srt_pkg::TableDepth
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_command,
   input  wire  [15:0] req_line_key,
   input  wire  [9:0]  req_stop_count,
   input  wire  [15:0] req_ride_duration,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic signed [6:0]  rsp_found_index,
   output logic [6:0]  rsp_entry_count,
   output logic [23:0] rsp_mean_duration_q8,
   output logic [9:0]  rsp_mean_stops,
   output logic signed [16:0] rsp_shortest_key,
   output logic        rsp_table_empty,
   output logic        rsp_overflow,
   output logic        rsp_removed
);
   localparam int CntW = $clog2(TABLE_DEPTH + 1);
   localparam int IdxW = $clog2(TABLE_DEPTH);
   localparam int SumDW = 16 + CntW;
   localparam int SumSW = 10 + CntW;
   localparam int NumW = SumDW + 8;

   srt_pkg::state_type    state_ff, state_in;
   srt_pkg::command_type  cmd_ff;
   srt_pkg::record_type   req_rec_ff;
   srt_pkg::cell_ctrl_type ctrl;
   srt_pkg::record_type   recs [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] gt_vec, eq_vec, take_new, take_right;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] scan_ff;
   logic [IdxW-1:0] del_pos;
   logic            del_hit;
   logic            found_ff;
   logic [IdxW-1:0] found_idx_ff;
   logic [SumDW-1:0] sum_d_ff;
   logic [SumSW-1:0] sum_s_ff;
   logic [15:0]     best_d_ff, best_k_ff;
   logic            div_start, div_d_done, div_s_done;
   logic [NumW-1:0] q_d;
   logic [SumSW-1:0] q_s;
   logic            ins_done_ff, del_done_ff;
   logic            out_valid_ff;
   logic signed [6:0]  o_idx_ff;
   logic [6:0]  o_cnt_ff;
   logic [23:0] o_mdur_ff;
   logic [9:0]  o_ms_ff;
   logic signed [16:0] o_sk_ff;
   logic        o_emp_ff, o_ovf_ff, o_rem_ff;
   logic        accept;
   srt_pkg::record_type head;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != srt_pkg::ST_IDLE) || out_valid_ff;
   assign head = recs[0];

   // Cell-local compares against the held request key.
   always_comb begin
      del_hit = 1'b0;
      del_pos = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         gt_vec[i] = (CntW'(i) < count_ff) && (recs[i].key > req_rec_ff.key);
         eq_vec[i] = (CntW'(i) < count_ff) && (recs[i].key == req_rec_ff.key);
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (eq_vec[i]) begin
            del_hit = 1'b1;
            del_pos = IdxW'(i);
         end
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (cmd_ff == srt_pkg::CMD_INSERT) begin
            take_right[i] = (i > 0) ? gt_vec[i-1] : 1'b0;
            take_new[i] = (CntW'(i) <= count_ff) && !gt_vec[i]
                          && ((i == 0) ? 1'b1 : !(gt_vec[i-1] == 1'b0 && CntW'(i) != count_ff
                          && !gt_vec[i])) && ((i == 0) || !gt_vec[i-1])
                          && ((CntW'(i) == count_ff) || gt_vec[i]);
         end else begin
            take_right[i] = (IdxW'(i) >= del_pos);
            take_new[i] = 1'b0;
         end
      end
   end

   generate
      for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         srt_cell u_cell (
            .clock(clock),
            .ctrl(ctrl),
            .take_new(take_new[g] || (ctrl.insert_shift && gt_vec[g]
                      && (g == 0 || !gt_vec[(g == 0) ? 0 : g-1]))),
            .take_right(take_right[g]),
            .new_rec(req_rec_ff),
            .left_rec(recs[(g == 0) ? 0 : g-1]),
            .right_rec(recs[(g + 1) % TABLE_DEPTH]),
            .rec(recs[g])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srt_pkg::ST_IDLE:   if (accept) state_in = srt_pkg::ST_SCAN;
         srt_pkg::ST_SCAN: begin
            if (cmd_ff == srt_pkg::CMD_INSERT || cmd_ff == srt_pkg::CMD_DELETE) begin
               state_in = srt_pkg::ST_SHIFT;
            end else if (scan_ff == CntW'(TABLE_DEPTH - 1)) begin
               state_in = (cmd_ff == srt_pkg::CMD_STATS && count_ff != '0)
                          ? srt_pkg::ST_DIVIDE : srt_pkg::ST_RESULT;
            end
         end
         srt_pkg::ST_SHIFT:  state_in = srt_pkg::ST_RESULT;
         srt_pkg::ST_DIVIDE: if (div_d_done) state_in = srt_pkg::ST_RESULT;
         srt_pkg::ST_RESULT: state_in = srt_pkg::ST_IDLE;
         default:            state_in = srt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      div_start = 1'b0;
      count_in = count_ff;
      unique case (state_ff)
         srt_pkg::ST_SCAN: begin
            if (cmd_ff == srt_pkg::CMD_SEARCH || cmd_ff == srt_pkg::CMD_STATS) begin
               ctrl.rotate = 1'b1;
               div_start = (scan_ff == CntW'(TABLE_DEPTH - 1))
                           && (cmd_ff == srt_pkg::CMD_STATS) && (count_ff != '0);
            end
         end
         srt_pkg::ST_SHIFT: begin
            if (cmd_ff == srt_pkg::CMD_INSERT && count_ff != CntW'(TABLE_DEPTH)) begin
               ctrl.insert_shift = 1'b1;
               count_in = count_ff + 1'b1;
            end else if (cmd_ff == srt_pkg::CMD_DELETE && del_hit) begin
               ctrl.delete_shift = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= srt_pkg::command_type'(req_command);
         req_rec_ff <= '{key: req_line_key, stops: req_stop_count, dur: req_ride_duration};
         scan_ff <= '0;
         found_ff <= 1'b0;
         sum_d_ff <= '0;
         sum_s_ff <= '0;
         best_d_ff <= 16'hFFFF;
         best_k_ff <= '0;
      end else if (ctrl.rotate) begin
         scan_ff <= scan_ff + 1'b1;
         if (scan_ff < count_ff) begin
            if (!found_ff && head.key == req_rec_ff.key) begin
               found_ff <= 1'b1;
               found_idx_ff <= scan_ff[IdxW-1:0];
            end
            sum_d_ff <= sum_d_ff + SumDW'(head.dur);
            sum_s_ff <= sum_s_ff + SumSW'(head.stops);
            if (scan_ff == '0 || head.dur < best_d_ff) begin
               best_d_ff <= head.dur;
               best_k_ff <= head.key;
            end
         end
      end
      ins_done_ff <= ctrl.insert_shift;
      del_done_ff <= ctrl.delete_shift;
      if (state_ff == srt_pkg::ST_RESULT) begin
         o_idx_ff <= (cmd_ff == srt_pkg::CMD_SEARCH)
                     ? (found_ff ? 7'(found_idx_ff) : -7'sd1) : 7'sd0;
         o_cnt_ff <= 7'(count_ff);
         o_emp_ff <= (count_ff == '0);
         o_ovf_ff <= (cmd_ff == srt_pkg::CMD_INSERT) && (count_ff == CntW'(TABLE_DEPTH))
                     && !ins_done_ff;
         o_rem_ff <= (cmd_ff == srt_pkg::CMD_DELETE) && del_done_ff;
         if (cmd_ff == srt_pkg::CMD_STATS && count_ff != '0) begin
            o_mdur_ff <= q_d[23:0];
            o_ms_ff <= q_s[9:0];
            o_sk_ff <= {1'b0, best_k_ff};
         end else begin
            o_mdur_ff <= '0;
            o_ms_ff <= '0;
            o_sk_ff <= (cmd_ff == srt_pkg::CMD_STATS) ? -17'sd1 : 17'sd0;
         end
      end
      if (reset) begin
         state_ff <= srt_pkg::ST_IDLE;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == srt_pkg::ST_RESULT) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   srt_divider #(.NumWidth(NumW), .DenWidth(CntW)) u_div_dur (
      .clock(clock), .reset(reset), .start(div_start),
      .numer({(scan_ff < count_ff) ? sum_d_ff + SumDW'(head.dur) : sum_d_ff, 8'd0}),
      .denom(count_ff), .done(div_d_done), .quot(q_d)
   );
   srt_divider #(.NumWidth(SumSW), .DenWidth(CntW)) u_div_stops (
      .clock(clock), .reset(reset), .start(div_start),
      .numer((scan_ff < count_ff) ? sum_s_ff + SumSW'(head.stops) : sum_s_ff),
      .denom(count_ff), .done(div_s_done), .quot(q_s)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_found_index = o_idx_ff;
   assign rsp_entry_count = o_cnt_ff;
   assign rsp_mean_duration_q8 = o_mdur_ff;
   assign rsp_mean_stops = o_ms_ff;
   assign rsp_shortest_key = o_sk_ff;
   assign rsp_table_empty = o_emp_ff;
   assign rsp_overflow = o_ovf_ff;
   assign rsp_removed = o_rem_ff;

   `SRT_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= CntW'(TABLE_DEPTH))
   `SRT_ASSERT_IMPL(a_stall_busy, clock, reset, state_ff != srt_pkg::ST_IDLE, req_stall)
   `SRT_ASSERT_NEXT(a_result_valid, clock, reset, state_ff == srt_pkg::ST_RESULT, rsp_valid)
   `SRT_ASSERT_IMPL(a_div_done, clock, reset, div_d_done || div_s_done, state_ff == srt_pkg::ST_DIVIDE)
endmodule
`default_nettype wire
